// ===== hw/rtl/sorted_table_binary_search_top_defines.svh =====
// Assertion macros for the sorted table search block.
// Used by sorted_table_binary_search_top.sv; expects clk_i and rst_ni in scope.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define STBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define STBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/stbs_pkg.sv =====
// Shared types and constants for the sorted table search block.
// No dependencies.
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int CFG_W           = 7;
  localparam int IDX_W           = 6;
  localparam int DATA_W          = 32;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_PROBE
  } stbs_state_e;

endpackage

// ===== hw/rtl/sorted_table_binary_search_top.sv =====
// Write: a new transaction may follow in the next cycle; no result.
// Search: one probe per cycle, up to floor(log2(TABLE_DEPTH))+1 probes (7 at 64),
// each probe evaluated on the table memory's registered read data.
// found_o/done_o strobe after the last probe; an empty range answers next cycle.
// busy stays high while probing.
// Reset clears control and the entry count; table contents are undefined until written.
// Top level of the sorted table search block: table memory and probe sequencer.
// Depends on stbs_pkg and sorted_table_binary_search_top_defines.svh.
`timescale 1ns / 1ps
`include "sorted_table_binary_search_top_defines.svh"

module sorted_table_binary_search_top
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     kind_i,
  input  logic [IDX_W-1:0]         entry_index_i,
  input  logic signed [DATA_W-1:0] item_value_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  output logic                     done_o,
  output logic                     found_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = (CW > CFG_W) ? CW : CFG_W;

  stbs_state_e state_q, state_d;

  logic [CFG_W-1:0]         cfg_q;
  logic [CW-1:0]            lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]            mid_q, mid_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic                     done_q, done_d, found_q, found_d;

  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rdata_q;
  logic                     rd_en, wr_en;
  logic [AW-1:0]            rd_addr, wr_addr;

  logic                     accept, search_acc, idx_ok;
  logic [CW-1:0]            hi_sat;
  logic                     probe_hit, key_lt, more;
  logic [CW-1:0]            nlo, nhi;
  logic                     mid_in_range, probe_start, search_live;

  function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return AW'(sum >> 1);
  endfunction

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign search_acc = accept && (kind_i == KIND_SEARCH);
  assign idx_ok     = 32'(entry_index_i) < 32'(TABLE_DEPTH);
  assign hi_sat     = (SW'(cfg_q) > SW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cfg_q);

  // probe evaluation on the registered read data
  assign probe_hit = (rdata_q == key_q);
  assign key_lt    = (key_q < rdata_q);
  assign nlo       = key_lt ? lo_q : CW'(mid_q) + CW'(1);
  assign nhi       = key_lt ? CW'(mid_q) : hi_q;
  assign more      = (nlo < nhi);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (search_acc && (hi_sat != '0)) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (probe_hit || !more) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    key_d   = key_q;
    done_d  = 1'b0;
    found_d = 1'b0;
    rd_en   = 1'b0;
    rd_addr = mid_of(nlo, nhi);
    wr_en   = 1'b0;
    wr_addr = AW'(entry_index_i);
    case (state_q)
      ST_IDLE: begin
        if (accept && (kind_i == KIND_WRITE)) begin
          wr_en = idx_ok;
        end else if (search_acc) begin
          key_d = item_value_i;
          if (hi_sat == '0) begin
            done_d = 1'b1;
          end else begin
            lo_d    = '0;
            hi_d    = hi_sat;
            rd_addr = mid_of('0, hi_sat);
            mid_d   = rd_addr;
            rd_en   = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (probe_hit) begin
          done_d  = 1'b1;
          found_d = 1'b1;
        end else if (more) begin
          lo_d    = nlo;
          hi_d    = nhi;
          mid_d   = rd_addr;
          rd_en   = 1'b1;
        end else begin
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= item_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cfg_q   <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      found_q <= found_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    key_q <= key_d;
  end

  assign done_o  = done_q;
  assign found_o = found_q;

  assign mid_in_range = (CW'(mid_q) >= lo_q) && (CW'(mid_q) < hi_q);
  assign probe_start  = search_acc && (hi_sat != '0);
  assign search_live  = (state_q == ST_PROBE) || search_acc;

  `STBS_ASSERT(a_probe_range, (state_q != ST_PROBE) || (lo_q < hi_q), "probe with empty range")
  `STBS_ASSERT(a_probe_mid, (state_q != ST_PROBE) || mid_in_range, "probe address outside range")
  `STBS_ASSERT_NEXT(a_search_start, probe_start, state_q == ST_PROBE, "search did not probe")
  `STBS_ASSERT_NEXT(a_done_source, !search_live, !done_q, "result without a search")

endmodule

// ===== tb/sorted_table_binary_search_checker.sv =====
// Checker for the sorted table search block: tracks table writes and the entry count,
// predicts the found flag of each search and compares it with the block's result.
// Depends on stbs_pkg.
`timescale 1ns / 1ps

module sorted_table_binary_search_checker
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic                     kind_i,
  input  logic [IDX_W-1:0]         entry_index_i,
  input  logic signed [DATA_W-1:0] item_value_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic                     done_i,
  input  logic                     found_i,
  output int                       mismatch_count_o,
  output int                       awaiting_count_o
);

  logic signed [DATA_W-1:0] entry_mirror [TABLE_DEPTH];
  logic [CFG_W-1:0]         entry_count_q;
  logic                     found_expected_q [$];
  logic                     expected_found;
  int                       mismatches = 0;

  function automatic logic predict_found(input logic signed [DATA_W-1:0] key);
    int lower;
    int upper;
    int mid;
    lower = 0;
    upper = (int'(entry_count_q) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_q);
    while (lower < upper) begin
      mid = (lower + upper) / 2;
      if (entry_mirror[mid] == key) return 1'b1;
      // signed compare: both operands are signed vectors
      if (key < entry_mirror[mid]) upper = mid;
      else lower = mid + 1;
    end
    return 1'b0;
  endfunction

  // Inputs are driven with NBAs at the edge, so values seen here are the pre-edge ones.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_expected_q.delete();
      entry_count_q = '0;
    end else begin
      if (done_i) begin
        if (found_expected_q.size() == 0) begin
          mismatches++;
          $error("found: result with no search outstanding, actual %0b", found_i);
        end else begin
          expected_found = found_expected_q.pop_front();
          if (found_i !== expected_found) begin
            mismatches++;
            $error("found mismatch: expected %0b, actual %0b", expected_found, found_i);
          end
        end
      end
      if (cfg_we_i) entry_count_q = cfg_wdata_i;
      if (start_i && !busy_i) begin
        if (kind_i == KIND_WRITE) begin
          if (int'(entry_index_i) < TABLE_DEPTH) entry_mirror[entry_index_i] = item_value_i;
        end else begin
          found_expected_q.push_back(predict_found(item_value_i));
        end
      end
    end
    awaiting_count_o = found_expected_q.size();
    mismatch_count_o = mismatches;
  end

endmodule

// ===== tb/tb_sorted_table_binary_search_top.sv =====
// Testbench top for sorted_table_binary_search_top: clock, reset, table fills, searches
// and entry-count writes; verdict from the checker's mismatch count.
// Depends on stbs_pkg, sorted_table_binary_search_top and sorted_table_binary_search_checker.
`timescale 1ns / 1ps

module tb_sorted_table_binary_search_top
  import stbs_pkg::*;
();

  localparam int SETTLE_CYCLES      = 12;
  localparam int PHASES             = 8;
  localparam int SEARCHES_PER_PHASE = 90;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     start         = 1'b0;
  logic                     kind_i        = KIND_WRITE;
  logic [IDX_W-1:0]         entry_index_i = '0;
  logic signed [DATA_W-1:0] item_value_i  = '0;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]         cfg_wdata_i   = '0;
  logic                     busy;
  logic                     done_o;
  logic                     found_o;
  int                       mismatch_count;
  int                       awaiting_count;

  // stimulus bookkeeping only: lets searches aim at stored values
  logic signed [DATA_W-1:0] written_values [DEF_TABLE_DEPTH];
  logic [CFG_W-1:0]         active_count    = '0;
  int                       sender_idle_pct = 0;
  int                       sent_total      = 0;
  int                       sent_searches   = 0;
  int                       count_settings  = 0;

  always #5 clk_i = ~clk_i;

  sorted_table_binary_search_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .item_value_i  (item_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .found_o       (found_o)
  );

  sorted_table_binary_search_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .kind_i           (kind_i),
    .entry_index_i    (entry_index_i),
    .item_value_i     (item_value_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_i           (done_o),
    .found_i          (found_o),
    .mismatch_count_o (mismatch_count),
    .awaiting_count_o (awaiting_count)
  );

  task automatic send_transaction(input logic kind, input logic [IDX_W-1:0] idx,
                                  input logic signed [DATA_W-1:0] val);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start         <= 1'b1;
    kind_i        <= kind;
    entry_index_i <= idx;
    item_value_i  <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent_total++;
    if (kind == KIND_SEARCH) sent_searches++;
  endtask

  task automatic write_entry(input int idx, input logic signed [DATA_W-1:0] val);
    written_values[idx] = val;
    send_transaction(KIND_WRITE, IDX_W'(idx), val);
  endtask

  task automatic search_key(input logic signed [DATA_W-1:0] key);
    send_transaction(KIND_SEARCH, IDX_W'($urandom()), key);
  endtask

  // Hold off the sender until every search has answered and the block has settled.
  task automatic drain();
    start <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (awaiting_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_entry_count(input logic [CFG_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    active_count = value;
    count_settings++;
  endtask

  // Ascending contents: dense runs carry duplicates, sparse ones span most of the range.
  task automatic fill_sorted(input bit dense);
    longint acc;
    acc = dense ? longint'($urandom_range(0, 200)) - 100
                : -64'sd2147483648 + longint'($urandom_range(0, 32'h7fff_ffff));
    for (int i = 0; i < DEF_TABLE_DEPTH; i++) begin
      write_entry(i, acc[DATA_W-1:0]);
      acc += dense ? longint'($urandom_range(0, 3)) : longint'($urandom_range(0, 32'h01ff_ffff));
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_key();
    int covered;
    int sel;
    covered = (int'(active_count) > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : int'(active_count);
    sel = $urandom_range(0, 99);
    if (covered > 0 && sel < 55) return written_values[$urandom_range(0, covered - 1)];
    if (covered > 0 && sel < 70) begin
      if ($urandom_range(0, 1)) return written_values[$urandom_range(0, covered - 1)] + 1;
      return written_values[$urandom_range(0, covered - 1)] - 1;
    end
    if (sel < 76) return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    return $urandom();
  endfunction

  initial begin
    int               idle_plan [PHASES];
    logic [CFG_W-1:0] count_choice;
    idle_plan = '{0, 62, 21, 0, 62, 21, 0, 62};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty range answers without touching the table
    set_entry_count('0);
    search_key('0);
    search_key(VAL_MIN);

    for (int i = 0; i < DEF_TABLE_DEPTH; i++) begin
      if (i == 0) write_entry(i, VAL_MIN);
      else if (i == DEF_TABLE_DEPTH - 1) write_entry(i, VAL_MAX);
      else write_entry(i, i * 1000 - 32000);
    end

    set_entry_count(CFG_W'(DEF_TABLE_DEPTH));
    search_key(VAL_MIN);
    search_key(VAL_MAX);
    search_key('0);
    search_key(500);
    search_key(VAL_MIN + 1);
    search_key(VAL_MAX - 1);
    search_key(written_values[17]);

    // count past the table end saturates
    set_entry_count('1);
    search_key(VAL_MAX);
    search_key(30000);

    set_entry_count(CFG_W'(1));
    search_key(VAL_MIN);
    search_key('0);

    // break the ordering: same probe path, found reflects only those probes
    write_entry(32, VAL_MAX);
    write_entry(0, 5);
    set_entry_count(CFG_W'(DEF_TABLE_DEPTH));
    search_key('0);
    search_key(VAL_MAX);
    search_key(5);
    search_key(-31000);

    for (int p = 0; p < PHASES; p++) begin
      sender_idle_pct = idle_plan[p];
      fill_sorted(p % 2 == 0);
      case (p)
        1:       count_choice = CFG_W'($urandom_range(2, DEF_TABLE_DEPTH - 1));
        3:       count_choice = CFG_W'(1);
        4:       count_choice = '0;
        5:       count_choice = CFG_W'($urandom_range(DEF_TABLE_DEPTH + 1, 127));
        6:       count_choice = '1;
        default: count_choice = CFG_W'(DEF_TABLE_DEPTH);
      endcase
      set_entry_count(count_choice);
      for (int s = 0; s < SEARCHES_PER_PHASE; s++) begin
        if (p == 2 && s == SEARCHES_PER_PHASE / 2) drain();
        if ($urandom_range(0, 99) < 4)
          write_entry($urandom_range(0, DEF_TABLE_DEPTH - 1), $urandom());
        else
          search_key(pick_key());
      end
    end

    drain();
    $display("Sent %0d transactions (%0d searches) under %0d entry-count settings.",
             sent_total, sent_searches, count_settings);
    $display("Settings spanned empty, single, partial, full and saturated counts.");
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
